>>> src/hcp_pkg.sv
package hcp_pkg;

   localparam int DIV_STAGES = 17;
   localparam int DIV_NUM_W  = 25;

   localparam logic [12:0] HUE_FULL  = 13'd5760;
   localparam logic [12:0] HUE_THIRD = 13'd1920;
   localparam logic [12:0] HUE_SIXTH = 13'd960;
   localparam logic [16:0] ONE_Q16   = 17'd65536;
   localparam logic [16:0] LIGHT_MIN = 17'd655;
   localparam logic [16:0] SAT_TOL   = 17'd66;
   localparam logic [16:0] HALF_TOL  = 17'd32703;
   // ceil(2^29 / 15), exact floor division by 15 for values below 2^21
   localparam logic [25:0] RECIP_15  = 26'd35791395;

   localparam logic [1:0] CSR_DELTA_HUE        = 2'd0;
   localparam logic [1:0] CSR_DELTA_LIGHTNESS  = 2'd1;
   localparam logic [1:0] CSR_DELTA_SATURATION = 2'd2;
   localparam logic [1:0] CSR_HUE_SHIFT_MODE   = 2'd3;

   typedef enum logic [1:0] {
      SEG_RISE,
      SEG_HIGH,
      SEG_FALL,
      SEG_LOW
   } seg_type;

   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [7:0] in_alpha;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } rsp_type;

   typedef struct packed {
      logic signed [13:0] delta_hue;
      logic signed [17:0] delta_lightness;
      logic signed [17:0] delta_saturation;
      logic               hue_shift_mode;
   } cfg_type;

   // fields that ride alongside the divider
   typedef struct packed {
      logic [16:0] light;
      logic        d_zero;
      logic [7:0]  alpha;
   } side_type;

   typedef struct packed {
      logic [DIV_NUM_W-1:0] sat_num;
      logic [7:0]           sat_den;
      logic [DIV_NUM_W-1:0] hue_num;
      logic [7:0]           hue_den;
      side_type             side;
   } front_type;

   typedef struct packed {
      logic [DIV_STAGES-1:0] q_sat;
      logic [DIV_STAGES-1:0] q_hue;
      side_type              side;
   } quo_type;

endpackage

>>> src/hcp_front.sv
module hcp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  hcp_pkg::req_type    in_data,
   output logic                out_valid,
   output hcp_pkg::front_type  out_data
);

   logic [7:0]         r, g, b, mx, mn, d;
   logic signed [11:0] k;
   logic [8:0]         sum;

   logic               s1_valid_ff;
   logic [8:0]         s1_sum_ff;
   logic [7:0]         s1_d_ff;
   logic signed [11:0] s1_k_ff;
   logic [7:0]         s1_alpha_ff;

   logic               s2_valid_ff;
   hcp_pkg::front_type s2_data_ff, s2_data_in;

   logic signed [11:0] six_d, k_wrap;
   logic [10:0]        k_pos;
   logic [20:0]        hue_num;
   logic [15:0]        sum128;
   logic [16:0]        div255;
   logic [16:0]        light;
   logic [7:0]         den;

   // min, max and hue sector
   always_comb begin
      r = in_data.in_red;
      g = in_data.in_green;
      b = in_data.in_blue;
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      sum = {1'b0, mx} + {1'b0, mn};
      if (r == mx) begin
         k = $signed({4'b0, g}) - $signed({4'b0, b});
      end else if (g == mx) begin
         k = $signed({3'b0, d, 1'b0}) + $signed({4'b0, b}) - $signed({4'b0, r});
      end else begin
         k = $signed({2'b0, d, 2'b0}) + $signed({4'b0, r}) - $signed({4'b0, g});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
      if (en) begin
         s1_sum_ff   <= sum;
         s1_d_ff     <= d;
         s1_k_ff     <= k;
         s1_alpha_ff <= in_data.in_alpha;
      end
   end

   // lightness by reciprocal, numerators and divisors for the divider
   always_comb begin
      six_d = $signed({2'b0, s1_d_ff, 2'b0}) + $signed({3'b0, s1_d_ff, 1'b0});
      k_wrap = (s1_k_ff < 0) ? (s1_k_ff + six_d) : s1_k_ff;
      k_pos = k_wrap[10:0];
      hue_num = {k_pos, 10'b0} - {4'b0, k_pos, 6'b0};
      // 65536*x/510 = 128x + floor(128x/255)
      sum128 = {s1_sum_ff[8:0], 7'b0};
      div255 = {1'b0, sum128} + {9'b0, sum128[15:8]} + 17'd1;
      light = {1'b0, sum128} + {8'b0, div255[16:8]};
      if (s1_sum_ff <= 9'd255) begin
         den = s1_sum_ff[7:0];
      end else begin
         den = 8'(9'd510 - s1_sum_ff);
      end
      s2_data_in.sat_num     = {1'b0, s1_d_ff, 16'b0};
      s2_data_in.sat_den     = den;
      s2_data_in.hue_num     = {4'b0, hue_num};
      s2_data_in.hue_den     = s1_d_ff;
      s2_data_in.side.light  = light;
      s2_data_in.side.d_zero = (s1_d_ff == 8'd0);
      s2_data_in.side.alpha  = s1_alpha_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

>>> src/hcp_divpair.sv
module hcp_divpair (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  hcp_pkg::front_type in_data,
   output logic               out_valid,
   output hcp_pkg::quo_type   out_data
);

   localparam int LAST = hcp_pkg::DIV_STAGES - 1;
   localparam int QW   = hcp_pkg::DIV_STAGES;

   logic [QW-1:0]     vld_ff;
   logic [7:0]        srem_ff [QW];
   logic [7:0]        srem_in [QW];
   logic [QW-1:0]     slow_ff [QW];
   logic [QW-1:0]     slow_in [QW];
   logic [QW-1:0]     squo_ff [QW];
   logic [QW-1:0]     squo_in [QW];
   logic [7:0]        sden_ff [QW];
   logic [7:0]        sden_in [QW];
   logic [7:0]        hrem_ff [QW];
   logic [7:0]        hrem_in [QW];
   logic [QW-1:0]     hlow_ff [QW];
   logic [QW-1:0]     hlow_in [QW];
   logic [QW-1:0]     hquo_ff [QW];
   logic [QW-1:0]     hquo_in [QW];
   logic [7:0]        hden_ff [QW];
   logic [7:0]        hden_in [QW];
   hcp_pkg::side_type side_ff [QW];
   hcp_pkg::side_type side_in [QW];

   logic [7:0]    srem_cur, sden_cur, hrem_cur, hden_cur;
   logic [QW-1:0] slow_cur, squo_cur, hlow_cur, hquo_cur;
   logic [8:0]    s9, h9;

   // one quotient bit per stage for each lane
   always_comb begin
      for (int i = 0; i < QW; i++) begin
         if (i == 0) begin
            srem_cur = in_data.sat_num[hcp_pkg::DIV_NUM_W-1:QW];
            slow_cur = in_data.sat_num[QW-1:0];
            squo_cur = '0;
            sden_cur = in_data.sat_den;
            hrem_cur = in_data.hue_num[hcp_pkg::DIV_NUM_W-1:QW];
            hlow_cur = in_data.hue_num[QW-1:0];
            hquo_cur = '0;
            hden_cur = in_data.hue_den;
            side_in[i] = in_data.side;
         end else begin
            srem_cur = srem_ff[i-1];
            slow_cur = slow_ff[i-1];
            squo_cur = squo_ff[i-1];
            sden_cur = sden_ff[i-1];
            hrem_cur = hrem_ff[i-1];
            hlow_cur = hlow_ff[i-1];
            hquo_cur = hquo_ff[i-1];
            hden_cur = hden_ff[i-1];
            side_in[i] = side_ff[i-1];
         end
         s9 = {srem_cur, slow_cur[QW-1]};
         if (s9 >= {1'b0, sden_cur}) begin
            srem_in[i] = 8'(s9 - {1'b0, sden_cur});
            squo_in[i] = {squo_cur[QW-2:0], 1'b1};
         end else begin
            srem_in[i] = s9[7:0];
            squo_in[i] = {squo_cur[QW-2:0], 1'b0};
         end
         slow_in[i] = {slow_cur[QW-2:0], 1'b0};
         sden_in[i] = sden_cur;
         h9 = {hrem_cur, hlow_cur[QW-1]};
         if (h9 >= {1'b0, hden_cur}) begin
            hrem_in[i] = 8'(h9 - {1'b0, hden_cur});
            hquo_in[i] = {hquo_cur[QW-2:0], 1'b1};
         end else begin
            hrem_in[i] = h9[7:0];
            hquo_in[i] = {hquo_cur[QW-2:0], 1'b0};
         end
         hlow_in[i] = {hlow_cur[QW-2:0], 1'b0};
         hden_in[i] = hden_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[QW-2:0], in_valid};
      end
      if (en) begin
         for (int i = 0; i < QW; i++) begin
            srem_ff[i] <= srem_in[i];
            slow_ff[i] <= slow_in[i];
            squo_ff[i] <= squo_in[i];
            sden_ff[i] <= sden_in[i];
            hrem_ff[i] <= hrem_in[i];
            hlow_ff[i] <= hlow_in[i];
            hquo_ff[i] <= hquo_in[i];
            hden_ff[i] <= hden_in[i];
            side_ff[i] <= side_in[i];
         end
      end
   end

   assign out_valid      = vld_ff[LAST];
   assign out_data.q_sat = squo_ff[LAST];
   assign out_data.q_hue = hquo_ff[LAST];
   assign out_data.side  = side_ff[LAST];

endmodule

>>> src/hcp_back.sv
module hcp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  hcp_pkg::cfg_type  cfg,
   input  logic              in_valid,
   input  hcp_pkg::quo_type  in_data,
   output logic              out_valid,
   output hcp_pkg::rsp_type  out_data
);

   function automatic logic [7:0] to_byte(input logic signed [19:0] v);
      logic [23:0] t;
      t = {v[15:0], 8'b0} - {8'b0, v[15:0]};
      if (v <= 0) begin
         return 8'd0;
      end else if (v >= $signed({3'b0, hcp_pkg::ONE_Q16})) begin
         return 8'd255;
      end else begin
         return t[23:16];
      end
   endfunction

   // stage 1: hue shift and wrap, clamps
   logic signed [14:0] h_base, h_sum;
   logic [12:0]        h_wrap;
   logic signed [18:0] s_sum, l_sum;
   logic [16:0]        s_clamp, l_clamp;

   logic        b1_valid_ff;
   logic [12:0] b1_h_ff;
   logic [16:0] b1_s_ff, b1_l_ff;
   logic [7:0]  b1_alpha_ff;

   always_comb begin
      h_base = in_data.side.d_zero ? -15'sd16 : $signed({2'b0, in_data.q_hue[12:0]});
      if (cfg.hue_shift_mode) begin
         h_sum = h_base + $signed({cfg.delta_hue[13], cfg.delta_hue});
      end else begin
         h_sum = $signed({cfg.delta_hue[13], cfg.delta_hue});
      end
      if (h_sum < -15'sd5760) begin
         h_wrap = 13'(h_sum + 15'sd11520);
      end else if (h_sum < 0) begin
         h_wrap = 13'(h_sum + 15'sd5760);
      end else if (h_sum > 15'sd11520) begin
         h_wrap = 13'(h_sum - 15'sd11520);
      end else if (h_sum > 15'sd5760) begin
         h_wrap = 13'(h_sum - 15'sd5760);
      end else begin
         h_wrap = h_sum[12:0];
      end
      s_sum = (in_data.side.d_zero ? 19'sd0 : $signed({2'b0, in_data.q_sat}))
            + $signed({cfg.delta_saturation[17], cfg.delta_saturation});
      if (s_sum < 0) begin
         s_clamp = 17'd0;
      end else if (s_sum > $signed({2'b0, hcp_pkg::ONE_Q16})) begin
         s_clamp = hcp_pkg::ONE_Q16;
      end else begin
         s_clamp = s_sum[16:0];
      end
      l_sum = $signed({2'b0, in_data.side.light})
            + $signed({cfg.delta_lightness[17], cfg.delta_lightness});
      if (l_sum < $signed({2'b0, hcp_pkg::LIGHT_MIN})) begin
         l_clamp = hcp_pkg::LIGHT_MIN;
      end else if (l_sum > $signed({2'b0, hcp_pkg::ONE_Q16})) begin
         l_clamp = hcp_pkg::ONE_Q16;
      end else begin
         l_clamp = l_sum[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else if (en) begin
         b1_valid_ff <= in_valid;
      end
      if (en) begin
         b1_h_ff     <= h_wrap;
         b1_s_ff     <= s_clamp;
         b1_l_ff     <= l_clamp;
         b1_alpha_ff <= in_data.side.alpha;
      end
   end

   // stage 2: l*s product, channel hues
   logic [12:0] hc_in [3];

   logic        b2_valid_ff;
   logic [33:0] b2_prod_ff;
   logic [16:0] b2_s_ff, b2_l_ff;
   logic        b2_grey_ff;
   logic [12:0] b2_hc_ff [3];
   logic [7:0]  b2_alpha_ff;

   always_comb begin
      if (b1_h_ff + hcp_pkg::HUE_THIRD > hcp_pkg::HUE_FULL) begin
         hc_in[0] = b1_h_ff + hcp_pkg::HUE_THIRD - hcp_pkg::HUE_FULL;
      end else begin
         hc_in[0] = b1_h_ff + hcp_pkg::HUE_THIRD;
      end
      hc_in[1] = b1_h_ff;
      if (b1_h_ff < hcp_pkg::HUE_THIRD) begin
         hc_in[2] = b1_h_ff + hcp_pkg::HUE_FULL - hcp_pkg::HUE_THIRD;
      end else begin
         hc_in[2] = b1_h_ff - hcp_pkg::HUE_THIRD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_valid_ff <= 1'b0;
      end else if (en) begin
         b2_valid_ff <= b1_valid_ff;
      end
      if (en) begin
         b2_prod_ff  <= b1_l_ff * b1_s_ff;
         b2_s_ff     <= b1_s_ff;
         b2_l_ff     <= b1_l_ff;
         b2_grey_ff  <= (b1_s_ff < hcp_pkg::SAT_TOL);
         b2_alpha_ff <= b1_alpha_ff;
         for (int c = 0; c < 3; c++) begin
            b2_hc_ff[c] <= hc_in[c];
         end
      end
   end

   // stage 3: m1, m2 and the hue segment of each channel
   logic [16:0]        ls;
   logic [17:0]        m2;
   logic signed [18:0] m1;
   hcp_pkg::seg_type   seg_in [3];
   logic [9:0]         frac_in [3];

   logic               b3_valid_ff;
   logic signed [18:0] b3_m1_ff;
   logic [17:0]        b3_m2_ff;
   hcp_pkg::seg_type   b3_seg_ff [3];
   logic [9:0]         b3_frac_ff [3];
   logic               b3_grey_ff;
   logic [7:0]         b3_gbyte_ff;
   logic [7:0]         b3_alpha_ff;

   always_comb begin
      ls = b2_prod_ff[32:16];
      if (b2_l_ff < hcp_pkg::HALF_TOL) begin
         m2 = {1'b0, b2_l_ff} + {1'b0, ls};
      end else begin
         m2 = {1'b0, b2_l_ff} + {1'b0, b2_s_ff} - {1'b0, ls};
      end
      m1 = $signed({1'b0, b2_l_ff, 1'b0}) - $signed({1'b0, m2});
      for (int c = 0; c < 3; c++) begin
         if (b2_hc_ff[c] < hcp_pkg::HUE_SIXTH) begin
            seg_in[c]  = hcp_pkg::SEG_RISE;
            frac_in[c] = b2_hc_ff[c][9:0];
         end else if (b2_hc_ff[c] < 13'd2880) begin
            seg_in[c]  = hcp_pkg::SEG_HIGH;
            frac_in[c] = 10'd0;
         end else if (b2_hc_ff[c] < 13'd3840) begin
            seg_in[c]  = hcp_pkg::SEG_FALL;
            frac_in[c] = 10'(13'd3840 - b2_hc_ff[c]);
         end else begin
            seg_in[c]  = hcp_pkg::SEG_LOW;
            frac_in[c] = 10'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b3_valid_ff <= 1'b0;
      end else if (en) begin
         b3_valid_ff <= b2_valid_ff;
      end
      if (en) begin
         b3_m1_ff    <= m1;
         b3_m2_ff    <= m2;
         b3_grey_ff  <= b2_grey_ff;
         b3_gbyte_ff <= to_byte($signed({3'b0, b2_l_ff}));
         b3_alpha_ff <= b2_alpha_ff;
         for (int c = 0; c < 3; c++) begin
            b3_seg_ff[c]  <= seg_in[c];
            b3_frac_ff[c] <= frac_in[c];
         end
      end
   end

   // stage 4: (m2 - m1) * fraction, never negative
   logic signed [18:0] diff_s;
   logic [17:0]        diff;

   logic               b4_valid_ff;
   logic [27:0]        b4_prod_ff [3];
   logic signed [18:0] b4_m1_ff;
   logic [17:0]        b4_m2_ff;
   hcp_pkg::seg_type   b4_seg_ff [3];
   logic               b4_grey_ff;
   logic [7:0]         b4_gbyte_ff;
   logic [7:0]         b4_alpha_ff;

   always_comb begin
      diff_s = $signed({1'b0, b3_m2_ff}) - b3_m1_ff;
      diff = diff_s[17:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b4_valid_ff <= 1'b0;
      end else if (en) begin
         b4_valid_ff <= b3_valid_ff;
      end
      if (en) begin
         b4_m1_ff    <= b3_m1_ff;
         b4_m2_ff    <= b3_m2_ff;
         b4_grey_ff  <= b3_grey_ff;
         b4_gbyte_ff <= b3_gbyte_ff;
         b4_alpha_ff <= b3_alpha_ff;
         for (int c = 0; c < 3; c++) begin
            b4_prod_ff[c] <= diff * b3_frac_ff[c];
            b4_seg_ff[c]  <= b3_seg_ff[c];
         end
      end
   end

   // stage 5: divide by 960 as a shift by 6 and a reciprocal of 15
   logic [46:0] rq [3];

   logic               b5_valid_ff;
   logic [17:0]        b5_q_ff [3];
   logic signed [18:0] b5_m1_ff;
   logic [17:0]        b5_m2_ff;
   hcp_pkg::seg_type   b5_seg_ff [3];
   logic               b5_grey_ff;
   logic [7:0]         b5_gbyte_ff;
   logic [7:0]         b5_alpha_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rq[c] = b4_prod_ff[c][26:6] * hcp_pkg::RECIP_15;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b5_valid_ff <= 1'b0;
      end else if (en) begin
         b5_valid_ff <= b4_valid_ff;
      end
      if (en) begin
         b5_m1_ff    <= b4_m1_ff;
         b5_m2_ff    <= b4_m2_ff;
         b5_grey_ff  <= b4_grey_ff;
         b5_gbyte_ff <= b4_gbyte_ff;
         b5_alpha_ff <= b4_alpha_ff;
         for (int c = 0; c < 3; c++) begin
            b5_q_ff[c]   <= rq[c][46:29];
            b5_seg_ff[c] <= b4_seg_ff[c];
         end
      end
   end

   // stage 6: channel value, byte conversion, grey select
   logic signed [19:0] v [3];
   logic [7:0]         byte_val [3];

   logic               b6_valid_ff;
   hcp_pkg::rsp_type   b6_data_ff, b6_data_in;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         case (b5_seg_ff[c])
            hcp_pkg::SEG_RISE, hcp_pkg::SEG_FALL: begin
               v[c] = $signed({b5_m1_ff[18], b5_m1_ff}) + $signed({2'b0, b5_q_ff[c]});
            end
            hcp_pkg::SEG_HIGH: begin
               v[c] = $signed({2'b0, b5_m2_ff});
            end
            default: begin
               v[c] = $signed({b5_m1_ff[18], b5_m1_ff});
            end
         endcase
         byte_val[c] = b5_grey_ff ? b5_gbyte_ff : to_byte(v[c]);
      end
      b6_data_in.out_red   = byte_val[0];
      b6_data_in.out_green = byte_val[1];
      b6_data_in.out_blue  = byte_val[2];
      b6_data_in.out_alpha = b5_alpha_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b6_valid_ff <= 1'b0;
      end else if (en) begin
         b6_valid_ff <= b5_valid_ff;
      end
      if (en) begin
         b6_data_ff <= b6_data_in;
      end
   end

   assign out_valid = b6_valid_ff;
   assign out_data  = b6_data_ff;

endmodule

>>> src/hsl_colorize_pixel.sv
// an accepted request runs through the front, the divider and the back stages to its result on rsp_valid
// throughput: one pixel per cycle unless the pipeline holds; the 17 stage divider pipeline sets the depth
// the whole pipeline holds while rsp_stall is high and a result is waiting
// reset clears all valid bits and sets delta_hue, delta_lightness and
// delta_saturation to zero and hue_shift_mode to one
module hsl_colorize_pixel (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hcp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hcp_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [1:0]       csr_index,
   input  logic [17:0]      csr_wdata
);

   hcp_pkg::cfg_type   cfg_ff;
   logic               en;
   logic               front_valid, div_valid;
   hcp_pkg::front_type front_data;
   hcp_pkg::quo_type   div_data;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delta_hue        <= '0;
         cfg_ff.delta_lightness  <= '0;
         cfg_ff.delta_saturation <= '0;
         cfg_ff.hue_shift_mode   <= 1'b1;
      end else if (csr_write_en) begin
         case (csr_index)
            hcp_pkg::CSR_DELTA_HUE:        cfg_ff.delta_hue <= csr_wdata[13:0];
            hcp_pkg::CSR_DELTA_LIGHTNESS:  cfg_ff.delta_lightness <= csr_wdata;
            hcp_pkg::CSR_DELTA_SATURATION: cfg_ff.delta_saturation <= csr_wdata;
            hcp_pkg::CSR_HUE_SHIFT_MODE:   cfg_ff.hue_shift_mode <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   hcp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   hcp_divpair u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   hcp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (div_valid),
      .in_data   (div_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

>>> sim/hsl_colorize_pixel_tb.sv
`timescale 1ns / 1ps

module hsl_colorize_pixel_tb;

   localparam int HUE_FULL_I  = 5760;
   localparam int HUE_THIRD_I = 1920;
   localparam int HUE_SIXTH_I = 960;
   localparam int ONE_I       = 65536;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   hcp_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   hcp_pkg::rsp_type rsp_data;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = hcp_pkg::CSR_DELTA_HUE;
   logic [17:0] csr_wdata = '0;

   // colorize settings as the block should hold them
   int hue_delta = 0;
   int light_delta = 0;
   int sat_delta = 0;
   bit shift_mode = 1'b1;

   hcp_pkg::rsp_type expected_pixels[$];
   int      mismatch_count = 0;
   int      pixel_count = 0;
   int      result_count = 0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;

   hsl_colorize_pixel dut (.*);

   always #6 clock = ~clock;

   function automatic int to_byte(int v);
      if (v <= 0) return 0;
      if (v >= ONE_I) return 255;
      return (v * 255) / ONE_I;
   endfunction

   function automatic int channel_level(int n1, int n2, int h);
      if (h > HUE_FULL_I) h -= HUE_FULL_I;
      if (h < 0) h += HUE_FULL_I;
      if (h < HUE_SIXTH_I) return n1 + ((n2 - n1) * h) / HUE_SIXTH_I;
      if (h < 3 * HUE_SIXTH_I) return n2;
      if (h < 4 * HUE_SIXTH_I) return n1 + ((n2 - n1) * (4 * HUE_SIXTH_I - h)) / HUE_SIXTH_I;
      return n1;
   endfunction

   function automatic hcp_pkg::rsp_type colorize(hcp_pkg::req_type p);
      int r, g, b, mx, mn, d, h, l, s, t, m1, m2, ls, y;
      hcp_pkg::rsp_type o;
      r = p.in_red; g = p.in_green; b = p.in_blue;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      l = (ONE_I * (mx + mn)) / 510;
      if (d == 0) begin
         s = 0;
         h = -16;
      end else begin
         if (mx + mn <= 255) s = (ONE_I * d) / (mx + mn);
         else s = (ONE_I * d) / (510 - mx - mn);
         if (r == mx) t = HUE_SIXTH_I * (g - b);
         else if (g == mx) t = HUE_SIXTH_I * (2 * d + b - r);
         else t = HUE_SIXTH_I * (4 * d + r - g);
         if (t < 0) t += HUE_FULL_I * d;
         h = t / d;
      end
      h = shift_mode ? h + hue_delta : hue_delta;
      while (h < 0) h += HUE_FULL_I;
      while (h > HUE_FULL_I) h -= HUE_FULL_I;
      s = s + sat_delta;
      if (s < 0) s = 0;
      if (s > ONE_I) s = ONE_I;
      l = l + light_delta;
      if (l < 655) l = 655;
      if (l > ONE_I) l = ONE_I;
      if (s < 66) begin
         y = to_byte(l);
         o.out_red = y[7:0]; o.out_green = y[7:0]; o.out_blue = y[7:0];
      end else begin
         // product reaches 2^32, so it needs a 64 bit intermediate
         ls = int'((longint'(l) * longint'(s)) / longint'(ONE_I));
         m2 = (l < 32703) ? l + ls : l + s - ls;
         m1 = 2 * l - m2;
         o.out_red   = 8'(to_byte(channel_level(m1, m2, h + HUE_THIRD_I)));
         o.out_green = 8'(to_byte(channel_level(m1, m2, h)));
         o.out_blue  = 8'(to_byte(channel_level(m1, m2, h - HUE_THIRD_I)));
      end
      o.out_alpha = p.in_alpha;
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   // result checker with random receiver stall
   always @(posedge clock) begin
      hcp_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected result", rsp_data, 0);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_data.out_red != want.out_red)
                  report_mismatch("out_red", rsp_data.out_red, want.out_red);
               if (rsp_data.out_green != want.out_green)
                  report_mismatch("out_green", rsp_data.out_green, want.out_green);
               if (rsp_data.out_blue != want.out_blue)
                  report_mismatch("out_blue", rsp_data.out_blue, want.out_blue);
               if (rsp_data.out_alpha != want.out_alpha)
                  report_mismatch("out_alpha", rsp_data.out_alpha, want.out_alpha);
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_pixel(hcp_pkg::req_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_pixels.push_back(colorize(p));
      pixel_count++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, int value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= 18'(value);
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         hcp_pkg::CSR_DELTA_HUE:        hue_delta   = $signed(14'(value));
         hcp_pkg::CSR_DELTA_LIGHTNESS:  light_delta = $signed(18'(value));
         hcp_pkg::CSR_DELTA_SATURATION: sat_delta   = $signed(18'(value));
         hcp_pkg::CSR_HUE_SHIFT_MODE:   shift_mode  = value[0];
         default: begin
         end
      endcase
   endtask

   task automatic set_colorize(int dh, int dl, int ds, bit mode);
      drain();
      write_csr(hcp_pkg::CSR_DELTA_HUE, dh);
      write_csr(hcp_pkg::CSR_DELTA_LIGHTNESS, dl);
      write_csr(hcp_pkg::CSR_DELTA_SATURATION, ds);
      write_csr(hcp_pkg::CSR_HUE_SHIFT_MODE, mode);
   endtask

   function automatic hcp_pkg::req_type pixel(int r, int g, int b, int a);
      hcp_pkg::req_type p;
      p.in_red = r[7:0]; p.in_green = g[7:0]; p.in_blue = b[7:0]; p.in_alpha = a[7:0];
      return p;
   endfunction

   // extremes, greys, each hue sector, ties between channels
   task automatic test_directed;
      send_pixel(pixel(0, 0, 0, 0));
      send_pixel(pixel(255, 255, 255, 255));
      send_pixel(pixel(128, 128, 128, 170));
      send_pixel(pixel(255, 0, 0, 85));
      send_pixel(pixel(0, 255, 0, 1));
      send_pixel(pixel(0, 0, 255, 254));
      send_pixel(pixel(255, 255, 0, 3));
      send_pixel(pixel(0, 255, 255, 7));
      send_pixel(pixel(255, 0, 255, 9));
      send_pixel(pixel(200, 10, 60, 11));
      send_pixel(pixel(10, 60, 200, 13));
      send_pixel(pixel(60, 200, 10, 15));
      send_pixel(pixel(127, 128, 128, 16));
      send_pixel(pixel(1, 0, 0, 32));
      send_pixel(pixel(255, 254, 254, 64));
      send_pixel(pixel(128, 127, 0, 128));
   endtask

   task automatic test_random(int n);
      int r, g, b;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(255); g = $urandom_range(255); b = $urandom_range(255);
         if ($urandom_range(9) == 0) begin
            g = r; b = r;
         end else if ($urandom_range(9) == 0) begin
            g = r;
         end
         send_pixel(pixel(r, g, b, $urandom_range(255)));
      end
   endtask

   task automatic test_settings;
      set_colorize(5760, 65536, 65536, 1);
      test_directed();
      set_colorize(-5760, -65536, -65536, 1);
      test_directed();
      set_colorize(-8192, 131071, -131072, 0);
      test_directed();
      set_colorize(8191, -131072, 131071, 1);
      test_directed();
      set_colorize(5760, 0, 0, 0);
      test_directed();
      set_colorize(0, 0, 0, 0);
      test_directed();
   endtask

   task automatic test_idling;
      int modes[4][2] = '{'{0, 0}, '{70, 0}, '{0, 70}, '{28, 28}};
      for (int k = 0; k < 4; k++) begin
         send_idle_pct = modes[k][0];
         stall_pct     = modes[k][1];
         for (int j = 0; j < 4; j++) begin
            set_colorize($urandom_range(11520) - 5760, $urandom_range(131072) - 65536,
                         $urandom_range(131072) - 65536, $urandom_range(1));
            test_random(98);
            if (j == 0) begin
               set_colorize($urandom_range(16383), $urandom_range(262143),
                            $urandom_range(262143), $urandom_range(1));
               test_random(20);
            end
         end
      end
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_settings();
      test_idling();
      drain();
      $display("covered %0d pixels and %0d results over extreme and random settings",
               pixel_count, result_count);
      $display("idle phases: none, sender 70%%, receiver 70%%, both 28%%");
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("timeout");
      $display("end of test: mismatches");
      $finish;
   end

endmodule
